// ===== hw/rtl/nhb_pkg.sv =====
// ----------------------------------------------------------------------------
// nhb_pkg
// Shared types and constants of the network Hessian block builder: field
// widths, the classified pair item, queue status and the back-end states.
// ----------------------------------------------------------------------------
`default_nettype none

package nhb_pkg;

  localparam int NODE_W    = 10;
  localparam int COORD_W   = 32;
  localparam int MAG_W     = 32;
  localparam int PROD_W    = 2 * MAG_W;
  localparam int DSQ_W     = PROD_W + 2;
  localparam int ENTRY_W   = 40;
  localparam int N_ENTRIES = 6;
  localparam int Q_BITS    = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Axis pair of each symmetric entry, order xx, xy, xz, yy, yz, zz.
  localparam logic [1:0] PAIR_A [N_ENTRIES] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2};
  localparam logic [1:0] PAIR_B [N_ENTRIES] = '{2'd0, 2'd1, 2'd2, 2'd1, 2'd2, 2'd2};

  typedef struct packed {
    logic [NODE_W-1:0]       row;
    logic [NODE_W-1:0]       col;
    logic [2:0][MAG_W-1:0]   mag;
    logic [2:0]              neg;
    logic                    active;
    logic                    zero;
    logic                    row_end;
  } nhb_item_t;

  typedef struct packed {
    logic valid;
    logic full;
  } nhb_qstat_t;

  typedef struct packed {
    logic [NODE_W-1:0]                  row;
    logic [NODE_W-1:0]                  col;
    logic [N_ENTRIES-1:0][ENTRY_W-1:0]  entry;
    logic                               degen;
    logic                               last;
  } nhb_result_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SUM,
    BK_DIV,
    BK_ACC,
    BK_OFF,
    BK_DIAG
  } nhb_bk_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nhb_front.sv =====
// ----------------------------------------------------------------------------
// nhb_front
// Classifies one node pair: forms the exact coordinate differences, splits
// them into magnitude and sign, and flags active, coincident and row-end.
// ----------------------------------------------------------------------------
`default_nettype none

module nhb_front
  import nhb_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  wire logic [NODE_W-1:0]         row_node,
  input  wire logic [NODE_W-1:0]         col_node,
  input  wire logic signed [COORD_W-1:0] first_x,
  input  wire logic signed [COORD_W-1:0] first_y,
  input  wire logic signed [COORD_W-1:0] first_z,
  input  wire logic signed [COORD_W-1:0] second_x,
  input  wire logic signed [COORD_W-1:0] second_y,
  input  wire logic signed [COORD_W-1:0] second_z,
  input  wire logic                      linked,
  input  wire logic                      row_end,
  output nhb_item_t                      item,
  output logic                           keep
);

  logic [2:0][COORD_W-1:0] pos_a;
  logic [2:0][COORD_W-1:0] pos_b;
  logic [COORD_W:0]        diff [3];
  logic [COORD_W:0]        absd [3];
  logic                    in_range;

  assign pos_a = {first_z, first_y, first_x};
  assign pos_b = {second_z, second_y, second_x};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = {pos_a[k][COORD_W-1], pos_a[k]} - {pos_b[k][COORD_W-1], pos_b[k]};
      absd[k] = diff[k][COORD_W] ? (~diff[k] + 1'b1) : diff[k];
      // magnitude never exceeds 2^32 - 1
      item.mag[k] = absd[k][MAG_W-1:0];
      item.neg[k] = diff[k][COORD_W];
    end
  end

  assign in_range     = (32'(row_node) < MAX_NODES) && (32'(col_node) < MAX_NODES);
  assign item.row     = row_node;
  assign item.col     = col_node;
  assign item.active  = linked && (row_node != col_node) && in_range;
  assign item.zero    = (item.mag == '0);
  assign item.row_end = row_end;

  // drop pairs that cause no result
  assign keep = item.active || row_end;

endmodule

`default_nettype wire

// ===== hw/rtl/nhb_queue.sv =====
// ----------------------------------------------------------------------------
// nhb_queue
// Short FIFO of classified items between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module nhb_queue
  import nhb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  nhb_item_t wr_item,
  input  wire logic pop,
  output nhb_item_t rd_item,
  output nhb_qstat_t stat
);

  nhb_item_t         entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_item;
    end
  end

  assign rd_item    = entry_r[rd_ptr_r];
  assign stat.valid = (count_r != '0);
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// ===== hw/rtl/nhb_back.sv =====
// ----------------------------------------------------------------------------
// nhb_back
// Executes one pair: six products on a shared multiplier, the squared
// distance, six restoring quotient lanes, rounding, the saturating diagonal
// accumulate, and the output register for off-diagonal and diagonal blocks.
// ----------------------------------------------------------------------------
`default_nettype none

module nhb_back
  import nhb_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  nhb_qstat_t q_stat,
  input  nhb_item_t  q_item,
  output logic       pop,
  output nhb_result_t res,
  output logic       res_valid,
  input  wire logic  res_stall
);

  nhb_bk_state_t state_r, state_nxt;

  nhb_item_t          item_r;
  logic [2:0]         mul_cnt_r;
  logic [4:0]         div_cnt_r;
  logic [PROD_W-1:0]  prod_r [N_ENTRIES];
  logic [DSQ_W-1:0]   dsq_r;
  logic [DSQ_W-1:0]   rem_r  [N_ENTRIES];
  logic [Q_BITS-1:0]  quo_r  [N_ENTRIES];
  logic [ENTRY_W-1:0] blk_r  [N_ENTRIES];
  logic [ENTRY_W-1:0] diag_r [N_ENTRIES];
  logic               degen_r;
  nhb_result_t        out_r;
  logic               out_valid_r;

  logic               out_free;
  logic               load_off;
  logic               load_diag;

  logic [MAG_W-1:0]   mul_a, mul_b;
  logic [PROD_W-1:0]  mul_p;

  logic [DSQ_W:0]     shifted  [N_ENTRIES];
  logic [DSQ_W:0]     trial    [N_ENTRIES];
  logic               ge       [N_ENTRIES];
  logic [DSQ_W-1:0]   rem_nxt  [N_ENTRIES];

  logic [Q_BITS:0]    rnd      [N_ENTRIES];
  logic [ENTRY_W-1:0] mag_e    [N_ENTRIES];
  logic [ENTRY_W-1:0] val      [N_ENTRIES];
  logic [ENTRY_W:0]   acc_sum  [N_ENTRIES];
  logic [ENTRY_W-1:0] acc_sat  [N_ENTRIES];

  assign out_free = !out_valid_r || !res_stall;

  // ---------------- control ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    load_off  = 1'b0;
    load_diag = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (q_stat.valid) begin
          pop = 1'b1;
          if (!q_item.active) begin
            state_nxt = BK_DIAG;
          end else if (q_item.zero) begin
            state_nxt = BK_OFF;
          end else begin
            state_nxt = BK_MUL;
          end
        end
      end
      BK_MUL: begin
        if (mul_cnt_r == 3'(N_ENTRIES - 1)) begin
          state_nxt = BK_SUM;
        end
      end
      BK_SUM: begin
        state_nxt = BK_DIV;
      end
      BK_DIV: begin
        if (div_cnt_r == 5'(Q_BITS - 1)) begin
          state_nxt = BK_ACC;
        end
      end
      BK_ACC: begin
        state_nxt = BK_OFF;
      end
      BK_OFF: begin
        if (out_free) begin
          load_off  = 1'b1;
          state_nxt = item_r.row_end ? BK_DIAG : BK_IDLE;
        end
      end
      BK_DIAG: begin
        if (out_free) begin
          load_diag = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // ---------------- datapath ----------------
  assign mul_a = item_r.mag[PAIR_A[mul_cnt_r]];
  assign mul_b = item_r.mag[PAIR_B[mul_cnt_r]];
  assign mul_p = mul_a * mul_b;

  always_comb begin
    for (int k = 0; k < N_ENTRIES; k++) begin
      // first quotient step compares the unshifted product
      shifted[k] = (div_cnt_r == '0) ? {1'b0, rem_r[k]} : {rem_r[k], 1'b0};
      trial[k]   = shifted[k] - {1'b0, dsq_r};
      ge[k]      = (shifted[k] >= {1'b0, dsq_r});
      rem_nxt[k] = ge[k] ? trial[k][DSQ_W-1:0] : shifted[k][DSQ_W-1:0];

      // round half away from zero on the magnitude, then apply the sign
      rnd[k]     = {1'b0, quo_r[k]} + (Q_BITS + 1)'(1);
      mag_e[k]   = ENTRY_W'(rnd[k][Q_BITS:1]);
      val[k]     = (item_r.neg[PAIR_A[k]] ^ item_r.neg[PAIR_B[k]]) ? (~mag_e[k] + 1'b1)
                                                                    : mag_e[k];
      acc_sum[k] = {diag_r[k][ENTRY_W-1], diag_r[k]} + {val[k][ENTRY_W-1], val[k]};
      if (acc_sum[k][ENTRY_W] != acc_sum[k][ENTRY_W-1]) begin
        acc_sat[k] = acc_sum[k][ENTRY_W] ? {1'b1, {(ENTRY_W-1){1'b0}}}
                                         : {1'b0, {(ENTRY_W-1){1'b1}}};
      end else begin
        acc_sat[k] = acc_sum[k][ENTRY_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r    <= q_item;
      mul_cnt_r <= '0;
      degen_r   <= q_item.zero;
      if (q_item.zero) begin
        for (int k = 0; k < N_ENTRIES; k++) blk_r[k] <= '0;
      end
    end
    if (state_r == BK_MUL) begin
      prod_r[mul_cnt_r] <= mul_p;
      mul_cnt_r         <= mul_cnt_r + 3'd1;
    end
    if (state_r == BK_SUM) begin
      dsq_r     <= DSQ_W'(prod_r[0]) + DSQ_W'(prod_r[3]) + DSQ_W'(prod_r[5]);
      div_cnt_r <= '0;
      for (int k = 0; k < N_ENTRIES; k++) rem_r[k] <= DSQ_W'(prod_r[k]);
    end
    if (state_r == BK_DIV) begin
      div_cnt_r <= div_cnt_r + 5'd1;
      for (int k = 0; k < N_ENTRIES; k++) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= {quo_r[k][Q_BITS-2:0], ge[k]};
      end
    end
    if (state_r == BK_ACC) begin
      for (int k = 0; k < N_ENTRIES; k++) blk_r[k] <= ~val[k] + 1'b1;
    end
  end

  // running diagonal block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < N_ENTRIES; k++) diag_r[k] <= '0;
    end else if (load_diag) begin
      for (int k = 0; k < N_ENTRIES; k++) diag_r[k] <= '0;
    end else if (state_r == BK_ACC) begin
      for (int k = 0; k < N_ENTRIES; k++) diag_r[k] <= acc_sat[k];
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_off || load_diag) begin
      out_valid_r <= 1'b1;
    end else if (!res_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_off) begin
      out_r.row   <= item_r.row;
      out_r.col   <= item_r.col;
      out_r.degen <= degen_r;
      out_r.last  <= !item_r.row_end;
      for (int k = 0; k < N_ENTRIES; k++) out_r.entry[k] <= blk_r[k];
    end else if (load_diag) begin
      out_r.row   <= item_r.row;
      out_r.col   <= item_r.row;
      out_r.degen <= 1'b0;
      out_r.last  <= 1'b1;
      for (int k = 0; k < N_ENTRIES; k++) out_r.entry[k] <= diag_r[k];
    end
  end

  assign res       = out_r;
  assign res_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/network_hessian_block_builder_core.sv =====
// ----------------------------------------------------------------------------
// network_hessian_block_builder_core
// Builds the 3x3 Hessian blocks of a node row from ordered node pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_*): one node pair per request, row by row, with both
//   Q16.16 positions, the connected flag and the row-end marker. Output
//   channel (out_*): one block per request, six symmetric Q9.30 entries;
//   out_last marks the final block caused by an input pair.
//   A connected, non-coincident pair passes the back-end states MUL, SUM,
//   DIV and ACC and gives its off-diagonal block from OFF; a row-end pair
//   then gives the diagonal block from DIAG. Pairs that give no block are
//   dropped before the queue; a row-end pair that adds nothing goes to DIAG.
//   The back end takes one pair at a time while the queue holds the next;
//   its pace is set by the 32-step quotient loop that runs all six entries
//   side by side; the products use one shared 32x32 multiplier in turn.
//   A two-entry queue sits between the classifier and the back end, so
//   in_stall rises only when that queue is full.
//   Reset clears the queue, the output valid flag and the diagonal block.
//   While out_stall is high the pending block holds and the back end waits.
// ----------------------------------------------------------------------------
`default_nettype none

module network_hessian_block_builder_core
  import nhb_pkg::*;
#(
  parameter int MAX_NODES = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,

  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [NODE_W-1:0]         in_row_node,
  input  wire logic [NODE_W-1:0]         in_col_node,
  input  wire logic signed [COORD_W-1:0] in_first_x,
  input  wire logic signed [COORD_W-1:0] in_first_y,
  input  wire logic signed [COORD_W-1:0] in_first_z,
  input  wire logic signed [COORD_W-1:0] in_second_x,
  input  wire logic signed [COORD_W-1:0] in_second_y,
  input  wire logic signed [COORD_W-1:0] in_second_z,
  input  wire logic                      in_linked,
  input  wire logic                      in_row_end,

  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [NODE_W-1:0]              out_block_row,
  output logic [NODE_W-1:0]              out_block_col,
  output logic signed [ENTRY_W-1:0]      out_entry_xx,
  output logic signed [ENTRY_W-1:0]      out_entry_xy,
  output logic signed [ENTRY_W-1:0]      out_entry_xz,
  output logic signed [ENTRY_W-1:0]      out_entry_yy,
  output logic signed [ENTRY_W-1:0]      out_entry_yz,
  output logic signed [ENTRY_W-1:0]      out_entry_zz,
  output logic                           out_degenerate,
  output logic                           out_last
);

  nhb_item_t   front_item;
  logic        front_keep;
  logic        q_push;
  logic        q_pop;
  nhb_item_t   q_item;
  nhb_qstat_t  q_stat;
  nhb_result_t res;

  nhb_front #(
    .MAX_NODES (MAX_NODES)
  ) u_front (
    .row_node (in_row_node),
    .col_node (in_col_node),
    .first_x  (in_first_x),
    .first_y  (in_first_y),
    .first_z  (in_first_z),
    .second_x (in_second_x),
    .second_y (in_second_y),
    .second_z (in_second_z),
    .linked   (in_linked),
    .row_end  (in_row_end),
    .item     (front_item),
    .keep     (front_keep)
  );

  assign in_stall = q_stat.full;
  assign q_push   = in_valid && !q_stat.full && front_keep;

  nhb_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (front_item),
    .pop     (q_pop),
    .rd_item (q_item),
    .stat    (q_stat)
  );

  nhb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_item    (q_item),
    .pop       (q_pop),
    .res       (res),
    .res_valid (out_valid),
    .res_stall (out_stall)
  );

  assign out_block_row  = res.row;
  assign out_block_col  = res.col;
  assign out_entry_xx   = res.entry[0];
  assign out_entry_xy   = res.entry[1];
  assign out_entry_xz   = res.entry[2];
  assign out_entry_yy   = res.entry[3];
  assign out_entry_yz   = res.entry[4];
  assign out_entry_zz   = res.entry[5];
  assign out_degenerate = res.degen;
  assign out_last       = res.last;

`ifndef ASSERT_OFF
  // an off-diagonal block that is not last is followed at once by its diagonal
  a_diag_follows : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=>
      out_valid && out_last && (out_block_row == out_block_col))
    else $error("diagonal block did not follow its off-diagonal block");

  a_degen_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      (out_block_row != out_block_col) && (out_entry_xx == 0) && (out_entry_xy == 0) &&
      (out_entry_xz == 0) && (out_entry_yy == 0) && (out_entry_yz == 0) &&
      (out_entry_zz == 0))
    else $error("degenerate block is not an all-zero off-diagonal block");

  a_offdiag_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_block_row != out_block_col) |->
      (out_entry_xx <= 0) && (out_entry_xx >= -40'sd1073741824) &&
      (out_entry_yy <= 0) && (out_entry_yy >= -40'sd1073741824) &&
      (out_entry_zz <= 0) && (out_entry_zz >= -40'sd1073741824))
    else $error("off-diagonal block diagonal entry out of range");
`endif

endmodule

`default_nettype wire
